// ===== rtl/core/dvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvs_pkg: shared types for the serial divider core
// Holds the sequencer state encoding.
// ----------------------------------------------------------------------------
package dvs_pkg;

    // Sequencer states of the divider.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEG_A,
        ST_NEG_D,
        ST_DIV,
        ST_NEG_Q,
        ST_NEG_R,
        ST_DONE
    } dvs_state_t;

endpackage

// ===== rtl/core/divider_64bit_signed_unsigned_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned_core: serial restoring integer divider
// Unsigned or signed division giving quotient, remainder and a zero flag.
// ----------------------------------------------------------------------------
// Each request takes a dividend, a divisor and an action bit (0 unsigned,
// 1 signed two's complement) and returns one result with the quotient
// truncated toward zero, the remainder (dividend minus quotient times
// divisor, modulo 2^DATA_WIDTH) and a divide-by-zero flag. A zero divisor
// gives an all-ones quotient and the dividend as the remainder. The core
// works on one request at a time. The quotient is resolved one bit per clock
// by a single shift-subtract unit. An unsigned request passes from acceptance
// through the divide loop (ST_DIV) to completion (ST_DONE); a signed request
// also passes ST_NEG_A and ST_NEG_D before the loop and ST_NEG_Q and ST_NEG_R
// after it, because the operand magnitudes and the signed results pass one at
// a time through one shared negation unit. A zero divisor skips the loop.
// The result sits in an output register, so the next request is accepted
// while the previous result still waits to be taken.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned_core #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [DATA_WIDTH-1:0] s_dividend,
    input  logic [DATA_WIDTH-1:0] s_divisor,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_quotient,
    output logic [DATA_WIDTH-1:0] m_remainder,
    output logic                  m_divide_by_zero
);

    import dvs_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);

    dvs_state_t state_reg, state_next;

    // The dividend shift register also collects the quotient: each step
    // shifts one dividend bit out at the top and one quotient bit in below.
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] d_reg, d_next;
    logic [DATA_WIDTH-1:0] r_reg, r_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  sgn_reg, sgn_next;
    logic                  na_reg, na_next;
    logic                  nd_reg, nd_next;
    logic                  dz_reg, dz_next;

    logic                  m_valid_reg, m_valid_next;
    logic [DATA_WIDTH-1:0] m_quotient_reg, m_quotient_next;
    logic [DATA_WIDTH-1:0] m_remainder_reg, m_remainder_next;
    logic                  m_dz_reg, m_dz_next;

    logic                  s_accept;
    logic                  out_free;
    logic [DATA_WIDTH-1:0] neg_x;
    logic [DATA_WIDTH-1:0] neg_y;
    logic [DATA_WIDTH-1:0] step_r;
    logic                  step_q;

    assign s_ready          = (state_reg == ST_IDLE);
    assign s_accept         = s_valid && s_ready;
    assign out_free         = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_quotient       = m_quotient_reg;
    assign m_remainder      = m_remainder_reg;
    assign m_divide_by_zero = m_dz_reg;

    // The negation unit sees whichever word the current state works on.
    always_comb begin
        unique case (state_reg)
            ST_NEG_D: neg_x = d_reg;
            ST_NEG_R: neg_x = r_reg;
            default:  neg_x = a_reg;
        endcase
    end

    dvs_negate #(.W(DATA_WIDTH)) u_negate (
        .x_in  (neg_x),
        .y_out (neg_y)
    );

    dvs_step #(.W(DATA_WIDTH)) u_step (
        .r_in   (r_reg),
        .bit_in (a_reg[DATA_WIDTH-1]),
        .d_in   (d_reg),
        .r_out  (step_r),
        .q_bit  (step_q)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_divisor == '0) begin
                        state_next = ST_DONE;
                    end else if (s_action) begin
                        state_next = ST_NEG_A;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_NEG_A: state_next = ST_NEG_D;
            ST_NEG_D: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = sgn_reg ? ST_NEG_Q : ST_DONE;
                end
            end
            ST_NEG_Q: state_next = ST_NEG_R;
            ST_NEG_R: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates for each state.
    always_comb begin
        a_next           = a_reg;
        d_next           = d_reg;
        r_next           = r_reg;
        cnt_next         = cnt_reg;
        sgn_next         = sgn_reg;
        na_next          = na_reg;
        nd_next          = nd_reg;
        dz_next          = dz_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_quotient_next  = m_quotient_reg;
        m_remainder_next = m_remainder_reg;
        m_dz_next        = m_dz_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    d_next   = s_divisor;
                    sgn_next = s_action;
                    na_next  = s_action && s_dividend[DATA_WIDTH-1];
                    nd_next  = s_action && s_divisor[DATA_WIDTH-1];
                    cnt_next = CW'(DATA_WIDTH - 1);
                    if (s_divisor == '0) begin
                        // Zero divisor: the answer is known at once.
                        dz_next = 1'b1;
                        a_next  = '1;
                        r_next  = s_dividend;
                    end else begin
                        dz_next = 1'b0;
                        a_next  = s_dividend;
                        r_next  = '0;
                    end
                end
            end
            ST_NEG_A: begin
                if (na_reg) begin
                    a_next = neg_y;
                end
            end
            ST_NEG_D: begin
                if (nd_reg) begin
                    d_next = neg_y;
                end
            end
            ST_DIV: begin
                a_next   = {a_reg[DATA_WIDTH-2:0], step_q};
                r_next   = step_r;
                cnt_next = cnt_reg - 1'b1;
            end
            ST_NEG_Q: begin
                // The quotient is negative when the operand signs differ.
                if (na_reg != nd_reg) begin
                    a_next = neg_y;
                end
            end
            ST_NEG_R: begin
                // The remainder takes the sign of the dividend.
                if (na_reg) begin
                    r_next = neg_y;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_quotient_next  = a_reg;
                    m_remainder_next = r_reg;
                    m_dz_next        = dz_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg           <= a_next;
        d_reg           <= d_next;
        r_reg           <= r_next;
        cnt_reg         <= cnt_next;
        sgn_reg         <= sgn_next;
        na_reg          <= na_next;
        nd_reg          <= nd_next;
        dz_reg          <= dz_next;
        m_quotient_reg  <= m_quotient_next;
        m_remainder_reg <= m_remainder_next;
        m_dz_reg        <= m_dz_next;
    end

    // A request with a zero divisor skips the iterations entirely.
    a_zero_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_divisor == '0) |=> (state_reg == ST_DONE))
        else $error("zero divisor request did not go straight to completion");

    // The last iteration leaves the divide loop.
    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == '0) |=>
        (state_reg == ST_NEG_Q || state_reg == ST_DONE))
        else $error("divide loop did not end after the last quotient bit");

    // A result appears only out of the completion state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result offered without a finished division");

    // A flagged result always carries the all-ones quotient.
    a_dz_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_dz_reg) |-> (m_quotient_reg == '1))
        else $error("divide-by-zero result with wrong quotient");

endmodule

// ===== rtl/core/dvs_negate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvs_negate: shared two's complement negation unit
// Negates one operand word; the sequencer time-shares it across operands.
// ----------------------------------------------------------------------------
module dvs_negate #(
    parameter int W = 64
) (
    input  logic [W-1:0] x_in,
    output logic [W-1:0] y_out
);

    assign y_out = {W{1'b0}} - x_in;

endmodule

// ===== rtl/core/dvs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvs_step: one restoring division step
// Shifts the next dividend bit into the partial remainder and subtracts the
// divisor when the result does not borrow.
// ----------------------------------------------------------------------------
module dvs_step #(
    parameter int W = 64
) (
    input  logic [W-1:0] r_in,
    input  logic         bit_in,
    input  logic [W-1:0] d_in,
    output logic [W-1:0] r_out,
    output logic         q_bit
);

    logic [W:0] shifted;
    logic [W:0] diff;

    assign shifted = {r_in, bit_in};
    assign diff    = shifted - {1'b0, d_in};
    // No borrow means the shifted remainder was at least the divisor.
    assign q_bit   = ~diff[W];
    assign r_out   = q_bit ? diff[W-1:0] : shifted[W-1:0];

endmodule
